FILE: rtl/cds_pkg.sv
// Shared types, command codes and calendar helpers for the date subtractor.
// Used by cds_front, cds_queue, cds_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

    localparam logic [2:0] CMD_DAY        = 3'd0;
    localparam logic [2:0] CMD_WEEK       = 3'd1;
    localparam logic [2:0] CMD_MONTH      = 3'd2;
    localparam logic [2:0] CMD_YEAR       = 3'd3;
    localparam logic [2:0] CMD_DECADE     = 3'd4;
    localparam logic [2:0] CMD_CENTURY    = 3'd5;
    localparam logic [2:0] CMD_MILLENNIUM = 3'd6;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_JAN = 4'd1;

    // floor(x / 100) = (x * RECIP_100) >> 19 for x below 16384
    localparam logic [12:0] RECIP_100 = 13'd5243;
    // floor(x / 12) = (x * RECIP_12) >> 19 for x below 65536
    localparam logic [15:0] RECIP_12  = 16'd43691;
    localparam int          RECIP_SH  = 19;

    localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                              5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // Classified item as it waits between front and back
    typedef struct packed {
        logic [4:0]  day;     // 1..31, month length not yet applied
        logic [3:0]  month;   // 1..12
        logic [13:0] year;    // 0..9999
        logic [2:0]  cmd;
        logic [15:0] count;
        logic [18:0] left;    // days to walk back (count or 7 * count)
        logic [12:0] cq;      // count / 12
        logic [25:0] sub;     // years to take off for year-type units
        logic [6:0]  yq;      // year / 100
    } cds_item_t;

    // Queue status seen by its two sides
    typedef struct packed {
        logic full;
        logic empty;
    } cds_qstat_t;

    function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        len = 5'd31;
        if (month == MONTH_FEB)
            len = leap ? 5'd29 : 5'd28;
        else if (month >= MONTH_JAN && month <= MONTH_DEC)
            len = MONTH_LEN[month - 4'd1];
        return len;
    endfunction

    // Leap test from year % 100 and the low bits of year / 100
    function automatic logic leap_from_div(input logic [6:0] rem100, input logic [1:0] q_low);
        return (rem100[1:0] == 2'd0) && ((rem100 != 7'd0) || (q_low == 2'd0));
    endfunction

    // Leap test from year % 400
    function automatic logic leap_from_mod400(input logic [8:0] ymod);
        return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cds_front.sv
// Front end: takes input transfers, clamps month and year, and precomputes
// the quotients and products the back end needs. Depends on cds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cds_front (
    input  logic                  in_valid,
    input  logic [4:0]            day_in,
    input  logic [3:0]            month_in,
    input  logic [13:0]           year_in,
    input  logic [2:0]            command,
    input  logic [15:0]           count,
    input  cds_pkg::cds_qstat_t   qstat,
    output logic                  in_ready,
    output logic                  push,
    output cds_pkg::cds_item_t    item
);
    import cds_pkg::*;

    logic [3:0]  month_c;
    logic [13:0] year_c;
    logic [25:0] yq_prod;
    logic [31:0] cq_prod;
    logic [9:0]  unit;

    always_comb
    begin
        month_c = month_in;
        if (month_in < MONTH_JAN)
            month_c = MONTH_JAN;
        else if (month_in > MONTH_DEC)
            month_c = MONTH_DEC;
        year_c = (year_in > YEAR_MAX) ? YEAR_MAX : year_in;

        case (command)
            CMD_YEAR:       unit = 10'd1;
            CMD_DECADE:     unit = 10'd10;
            CMD_CENTURY:    unit = 10'd100;
            CMD_MILLENNIUM: unit = 10'd1000;
            default:        unit = 10'd0;
        endcase

        yq_prod = 26'(year_c) * 26'(RECIP_100);
        cq_prod = 32'(count) * 32'(RECIP_12);

        item.day   = (day_in == 5'd0) ? 5'd1 : day_in;
        item.month = month_c;
        item.year  = year_c;
        item.cmd   = command;
        item.count = count;
        item.left  = (command == CMD_WEEK) ? 19'(count) * 19'd7 : 19'(count);
        item.cq    = cq_prod[RECIP_SH +: 13];
        item.sub   = 26'(count) * 26'(unit);
        item.yq    = yq_prod[RECIP_SH +: 7];
    end

    assign in_ready = !qstat.full;
    assign push     = in_valid && !qstat.full;

endmodule

`default_nettype wire

FILE: rtl/cds_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on cds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cds_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cds_pkg::cds_item_t  push_item,
    input  logic                pop,
    output cds_pkg::cds_item_t  head,
    output cds_pkg::cds_qstat_t qstat
);
    import cds_pkg::*;

    cds_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign do_push = push && (fill_reg != 2'd2);
    assign do_pop  = pop && (fill_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (fill_reg == 2'd2);
    assign qstat.empty = (fill_reg == 2'd0);

endmodule

`default_nettype wire

FILE: rtl/cds_back.sv
// Back end: clamps the day, carries out the subtraction (month-per-cycle walk
// for day and week units, a short sequence otherwise) and holds the result register.
// Depends on cds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cds_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cds_pkg::cds_item_t  head,
    input  cds_pkg::cds_qstat_t qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          day_out,
    output logic [3:0]          month_out,
    output logic [13:0]         year_out,
    output logic                underflow
);
    import cds_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_TGT  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_LQ   = 3'd4;
    localparam logic [2:0] ST_LR   = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]  state_reg, state_next;
    cds_item_t   item_reg, item_next;
    logic [18:0] left_reg, left_next;
    logic [4:0]  rd_reg, rd_next;
    logic [3:0]  rm_reg, rm_next;
    logic [13:0] ry_reg, ry_next;
    logic [8:0]  ymod_reg, ymod_next;
    logic [4:0]  nd_reg, nd_next;
    logic        uf_reg, uf_next;
    logic [6:0]  lq_reg, lq_next;
    logic        ov_reg, ov_next;
    logic [4:0]  od_reg, od_next;
    logic [3:0]  om_reg, om_next;
    logic [13:0] oy_reg, oy_next;
    logic        ouf_reg, ouf_next;

    logic        out_free;
    logic [6:0]  rem100;
    logic        leap;
    logic [4:0]  len;
    logic [16:0] cq12;
    logic [3:0]  rem12;
    logic [3:0]  mm1;
    logic        borrow;
    logic [13:0] dy;
    logic [26:0] lq_prod;
    logic [3:0]  wm;

    assign out_free = !ov_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && !qstat.empty;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        left_next  = left_reg;
        rd_next    = rd_reg;
        rm_next    = rm_reg;
        ry_next    = ry_reg;
        ymod_next  = ymod_reg;
        nd_next    = nd_reg;
        uf_next    = uf_reg;
        lq_next    = lq_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        om_next    = om_reg;
        oy_next    = oy_reg;
        ouf_next   = ouf_reg;

        rem100  = 7'd0;
        leap    = 1'b0;
        len     = 5'd31;
        cq12    = 17'(item_reg.cq) * 17'd12;
        rem12   = 4'(17'(item_reg.count) - cq12);
        mm1     = rm_reg - 4'd1;
        borrow  = (mm1 < rem12);
        dy      = 14'(item_reg.cq) + 14'(borrow);
        lq_prod = 27'(ry_reg) * 27'(RECIP_100);
        wm      = (rm_reg == MONTH_JAN) ? MONTH_DEC : rm_reg - 4'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    item_next  = head;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Bring the day inside the month, keep the year mod 400
                rem100    = 7'(item_reg.year - 14'(item_reg.yq) * 14'd100);
                leap      = leap_from_div(rem100, item_reg.yq[1:0]);
                len       = days_in(leap, item_reg.month);
                nd_next   = (item_reg.day > len) ? len : item_reg.day;
                rd_next   = (item_reg.day > len) ? len : item_reg.day;
                rm_next   = item_reg.month;
                ry_next   = item_reg.year;
                ymod_next = 9'(item_reg.yq[1:0]) * 9'd100 + 9'(rem100);
                left_next = item_reg.left;
                uf_next   = 1'b0;
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                if (item_reg.cmd == CMD_DAY || item_reg.cmd == CMD_WEEK)
                begin
                    state_next = ST_WALK;
                end
                else if (item_reg.cmd == CMD_MONTH)
                begin
                    if (dy > ry_reg)
                    begin
                        uf_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ry_next    = ry_reg - dy;
                        rm_next    = borrow ? 4'(5'(mm1) + 5'd13 - 5'(rem12))
                                            : mm1 + 4'd1 - rem12;
                        state_next = ST_LQ;
                    end
                end
                else if (item_reg.cmd inside {[CMD_YEAR:CMD_MILLENNIUM]})
                begin
                    if (item_reg.sub > 26'(ry_reg))
                    begin
                        uf_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ry_next    = ry_reg - item_reg.sub[13:0];
                        state_next = ST_LQ;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LQ:
            begin
                lq_next    = lq_prod[RECIP_SH +: 7];
                state_next = ST_LR;
            end
            ST_LR:
            begin
                // Clamp the day to the target month
                rem100     = 7'(ry_reg - 14'(lq_reg) * 14'd100);
                leap       = leap_from_div(rem100, lq_reg[1:0]);
                len        = days_in(leap, rm_reg);
                rd_next    = (rd_reg > len) ? len : rd_reg;
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                // One month boundary per cycle
                if (left_reg >= 19'(rd_reg))
                begin
                    left_next = left_reg - 19'(rd_reg);
                    if (rm_reg == MONTH_JAN && ry_reg == 14'd0)
                    begin
                        uf_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (rm_reg == MONTH_JAN)
                        begin
                            ry_next   = ry_reg - 14'd1;
                            ymod_next = (ymod_reg == 9'd0) ? 9'd399 : ymod_reg - 9'd1;
                        end
                        rm_next = wm;
                        rd_next = days_in(leap_from_mod400(ymod_reg), wm);
                    end
                end
                else
                begin
                    rd_next    = rd_reg - 5'(left_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ouf_next   = uf_reg;
                    od_next    = uf_reg ? nd_reg : rd_reg;
                    om_next    = uf_reg ? item_reg.month : rm_reg;
                    oy_next    = uf_reg ? item_reg.year : ry_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        left_reg <= left_next;
        rd_reg   <= rd_next;
        rm_reg   <= rm_next;
        ry_reg   <= ry_next;
        ymod_reg <= ymod_next;
        nd_reg   <= nd_next;
        uf_reg   <= uf_next;
        lq_reg   <= lq_next;
        od_reg   <= od_next;
        om_reg   <= om_next;
        oy_reg   <= oy_next;
        ouf_reg  <= ouf_next;
    end

    assign out_valid = ov_reg;
    assign day_out   = od_reg;
    assign month_out = om_reg;
    assign year_out  = oy_reg;
    assign underflow = ouf_reg;

endmodule

`default_nettype wire

FILE: rtl/calendar_date_subtractor_unit.sv
// Top level of the Gregorian date subtractor: front end, item queue, back end.
// Depends on cds_pkg, cds_front, cds_queue and cds_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// s_axis    in   tdata: day_in[4:0] month_in[8:5] year_in[22:9] count[38:23];
//                tuser: command[2:0]
// m_axis    out  tdata: day_out[4:0] month_out[8:5] year_out[22:9];
//                tuser: underflow
//
// After the queue pop, month, year, decade, century and millennium units
// step through ST_NORM, ST_TGT, ST_LQ, ST_LR and ST_DONE (ST_NORM, ST_TGT
// and ST_DONE when the result underflows); day and week units step through
// ST_NORM and ST_TGT, walk back one month boundary per cycle in ST_WALK, then
// ST_DONE (about 2160 boundaries for 65535 days, about 15080 for 65535 weeks).
// Reset (rst_n low) empties the queue and drops any pending result.
// The queue takes up to two transfers while the back end works or the
// result register waits on m_axis_tready; each side stalls on its own.

module calendar_date_subtractor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // day_in, month_in, year_in, count, pad
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // day_out, month_out, year_out, pad
    output logic        m_axis_tuser    // underflow
);
    import cds_pkg::*;

    cds_item_t  push_item;
    cds_item_t  head;
    cds_qstat_t qstat;
    logic       push;
    logic       pop;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [13:0] year_out;

    // Classify the incoming transfer
    cds_front u_front (
        .in_valid (s_axis_tvalid),
        .day_in   (s_axis_tdata[4:0]),
        .month_in (s_axis_tdata[8:5]),
        .year_in  (s_axis_tdata[22:9]),
        .command  (s_axis_tuser),
        .count    (s_axis_tdata[38:23]),
        .qstat    (qstat),
        .in_ready (s_axis_tready),
        .push     (push),
        .item     (push_item)
    );

    // Hold classified items until the back end is free
    cds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Execute and register the result
    cds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out),
        .underflow (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, year_out, month_out, day_out};

endmodule

`default_nettype wire

FILE: bench/calendar_date_subtractor_unit_test.sv
// Self-checking bench for calendar_date_subtractor_unit: directed table then random dates.
// Holds its own date arithmetic model; depends on cds_pkg and the RTL top level only.
`timescale 1ns / 1ps

module calendar_date_subtractor_unit_test;

    import cds_pkg::*;

    // Command 7 has no name in the package; the block passes the date through.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 245;
    localparam int DRAIN_AT     = 120;   // random item before which the sender waits for all results
    localparam int TAIL_CYCLES  = 30;

    // One request as it travels on s_axis
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  cmd;
        logic [15:0] count;
    } date_req_t;

    // One result as it travels on m_axis
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        underflow;
    } date_res_t;

    // Directed row: a request plus, where it is obvious, the date it must give
    typedef struct packed {
        date_req_t req;
        logic      known;
        date_res_t res;
    } plan_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // day_in, month_in, year_in, count, pad
    logic [2:0]  s_axis_tuser  = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // day_out, month_out, year_out, pad
    logic        m_axis_tuser;         // underflow

    date_res_t   pending_dates[$];     // results owed by the block, oldest first
    plan_row_t   directed_plan[$];
    int          fault_count = 0;
    int          burst_left  = 0;      // transfers left in the current sender burst
    int          ready_mode  = 0;
    int          ready_span  = 0;

    calendar_date_subtractor_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gregorian leap rule: every fourth year, except centuries not divisible by 400
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Predict the date count units before the request's date
    function automatic date_res_t subtract_date(input date_req_t q);
        int unsigned d, m, y, rd, rm, ry, len, left, total, unit_yrs, span;
        bit          uf;
        date_res_t   r;
        d  = q.day;
        m  = q.month;
        y  = q.year;
        uf = 1'b0;
        // bring the date into range first
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        if (y > 9999)
            y = 9999;
        if (d < 1)
            d = 1;
        len = month_days(y, m);
        if (d > len)
            d = len;
        rd = d;
        rm = m;
        ry = y;
        unit_yrs = 0;
        case (q.cmd)
            CMD_DAY, CMD_WEEK:
            begin
                left = q.count;
                if (q.cmd == CMD_WEEK)
                    left = left * 7;
                // walk back one month at a time while the remainder covers it
                while (!uf && left >= rd)
                begin
                    left -= rd;
                    if (rm == 1)
                    begin
                        if (ry == 0)
                            uf = 1'b1;
                        else
                        begin
                            ry -= 1;
                            rm = 12;
                        end
                    end
                    else
                        rm -= 1;
                    if (!uf)
                        rd = month_days(ry, rm);
                end
                if (!uf)
                    rd -= left;
            end
            CMD_MONTH:
            begin
                total = y * 12 + m - 1;
                if (q.count > total)
                    uf = 1'b1;
                else
                begin
                    total -= q.count;
                    ry = total / 12;
                    rm = total % 12 + 1;
                    len = month_days(ry, rm);
                    if (rd > len)
                        rd = len;
                end
            end
            CMD_YEAR:       unit_yrs = 1;
            CMD_DECADE:     unit_yrs = 10;
            CMD_CENTURY:    unit_yrs = 100;
            CMD_MILLENNIUM: unit_yrs = 1000;
            default: ;
        endcase
        if (unit_yrs != 0)
        begin
            span = q.count * unit_yrs;
            if (span > y)
                uf = 1'b1;
            else
            begin
                ry = y - span;
                len = month_days(ry, rm);
                if (rd > len)
                    rd = len;
            end
        end
        // on underflow hand back the range-corrected input date
        if (uf)
        begin
            rd = d;
            rm = m;
            ry = y;
        end
        r.day       = rd[4:0];
        r.month     = rm[3:0];
        r.year      = ry[13:0];
        r.underflow = uf;
        return r;
    endfunction

    task automatic add_row(input int d, input int m, input int y, input logic [2:0] c,
                           input int n, input bit known,
                           input int ed, input int em, input int ey, input bit euf);
        plan_row_t row;
        row.req.day       = d[4:0];
        row.req.month     = m[3:0];
        row.req.year      = y[13:0];
        row.req.cmd       = c;
        row.req.count     = n[15:0];
        row.known         = known;
        row.res.day       = ed[4:0];
        row.res.month     = em[3:0];
        row.res.year      = ey[13:0];
        row.res.underflow = euf;
        directed_plan.push_back(row);
    endtask

    // Offer one request; the sender idles between bursts of random length.
    // Returns right after the accepting edge with tvalid still high.
    task automatic send_date(input date_req_t req, input date_res_t res);
        int gap;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tdata  <= {1'b0, req.count, req.year, req.month, req.day};
        s_axis_tuser  <= req.cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_dates.push_back(res);
    endtask

    // Receiver: hold a stall mode for a random span, then pick a mode at random again (it may repeat)
    always @(posedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_span <= $urandom_range(8, 64);
        end
        else
            ready_span <= ready_span - 1;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare every result transfer against the oldest owed date
    always @(posedge clk)
    begin : result_check
        date_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result transfer with no date owed: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                fault_count++;
            end
            else
            begin
                want = pending_dates.pop_front();
                if (m_axis_tdata[4:0] !== want.day)
                begin
                    $error("day_out: expected %0d, got %0d", want.day, m_axis_tdata[4:0]);
                    fault_count++;
                end
                if (m_axis_tdata[8:5] !== want.month)
                begin
                    $error("month_out: expected %0d, got %0d", want.month, m_axis_tdata[8:5]);
                    fault_count++;
                end
                if (m_axis_tdata[22:9] !== want.year)
                begin
                    $error("year_out: expected %0d, got %0d", want.year, m_axis_tdata[22:9]);
                    fault_count++;
                end
                if (m_axis_tuser !== want.underflow)
                begin
                    $error("underflow: expected %0d, got %0d", want.underflow, m_axis_tuser);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        date_req_t   req;
        date_res_t   res;
        int unsigned yr, mo, dy, ycl, mcl, dim, cnt, unit_yrs, pick;

        // ---- directed table: day month year command count | known? day month year uf
        add_row( 1,  1,     0, CMD_DAY,            1, 1,  1,  1,    0, 1); // first day, underflow
        add_row( 1,  1,     0, CMD_DAY,            0, 1,  1,  1,    0, 0);
        add_row(31, 12,  9999, CMD_DAY,        65535, 0,  0,  0,    0, 0); // longest day walk
        add_row(31, 12,  9999, CMD_WEEK,       65535, 0,  0,  0,    0, 0); // longest week walk
        add_row(15,  6,  2000, CMD_MONTH,          0, 1, 15,  6, 2000, 0);
        add_row(31,  3,  2024, CMD_MONTH,          1, 1, 29,  2, 2024, 0); // clamp to leap Feb
        add_row(31,  3,  1900, CMD_MONTH,          1, 1, 28,  2, 1900, 0); // century not leap
        add_row(29,  2,  2000, CMD_YEAR,           1, 1, 28,  2, 1999, 0);
        add_row(29,  2,  2000, CMD_CENTURY,        4, 1, 29,  2, 1600, 0); // 400-year leap
        add_row(10,  5,  9999, CMD_MILLENNIUM,     9, 1, 10,  5,  999, 0);
        add_row(10,  5,  9999, CMD_MILLENNIUM,    10, 1, 10,  5, 9999, 1);
        add_row( 1,  1,     0, CMD_MONTH,          1, 1,  1,  1,    0, 1);
        add_row( 0,  0, 16383, CMD_UNUSED,     65535, 1,  1,  1, 9999, 0); // all fields clamped
        add_row(31, 15,  9999, CMD_DECADE,         0, 1, 31, 12, 9999, 0);
        add_row(31,  2,  2023, CMD_DAY,            0, 1, 28,  2, 2023, 0); // day past month end
        add_row(31,  4,  2001, CMD_YEAR,           0, 1, 30,  4, 2001, 0);
        add_row( 1,  3,  2024, CMD_DAY,            1, 1, 29,  2, 2024, 0);
        add_row( 1,  1,  2000, CMD_WEEK,           1, 1, 25, 12, 1999, 0); // across year end
        add_row( 5,  7,  1000, CMD_DECADE,       100, 1,  5,  7,    0, 0);
        add_row( 5,  7,  1000, CMD_DECADE,       101, 1,  5,  7, 1000, 1);
        add_row(12, 12,  9999, CMD_MONTH,      65535, 0,  0,  0,    0, 0);
        add_row(17,  8,     0, CMD_MONTH,          7, 1, 17,  1,    0, 0);
        add_row(31, 13,     0, CMD_DAY,          366, 1, 31, 12,    0, 1); // one day too far
        add_row(16, 10,  2023, CMD_WEEK,           2, 1,  2, 10, 2023, 0);
        add_row(31,  1,     0, CMD_DAY,           30, 0,  0,  0,    0, 0);

        // Hold reset low, then release it
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            res = directed_plan[i].known ? directed_plan[i].res
                                         : subtract_date(directed_plan[i].req);
            send_date(directed_plan[i].req, res);
        end

        // ---- random part: mostly valid dates, some out-of-range noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == DRAIN_AT)
            begin
                // drop valid and let the block empty out completely
                s_axis_tvalid <= 1'b0;
                burst_left = 0;
                while (pending_dates.size() != 0) @(posedge clk);
            end

            case ($urandom_range(0, 7))
                0:       yr = $urandom_range(0, 3);
                1:       yr = 9999 - $urandom_range(0, 3);
                2:       yr = $urandom_range(0, 16383);
                3:       yr = 100 * $urandom_range(0, 99);
                default: yr = $urandom_range(0, 9999);
            endcase
            mo  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            ycl = (yr > 9999) ? 9999 : yr;
            mcl = (mo < 1) ? 1 : (mo > 12) ? 12 : mo;
            dim = month_days(ycl, mcl);
            pick = $urandom_range(0, 7);
            if (pick == 0)
                dy = $urandom_range(0, 31);
            else if (pick == 1)
                dy = dim;
            else
                dy = $urandom_range(1, dim);

            req.day   = dy[4:0];
            req.month = mo[3:0];
            req.year  = yr[13:0];
            req.cmd   = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));

            unit_yrs = 0;
            case (req.cmd)
                CMD_DAY:
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        cnt = $urandom_range(0, 65535);
                    else if (pick < 4)
                        cnt = ycl * 365 + $urandom_range(0, 800);   // near the start of year 0
                    else
                        cnt = $urandom_range(0, 1500);
                end
                CMD_WEEK:
                    cnt = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 220);
                CMD_MONTH:
                    cnt = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                      : ycl * 12 + mcl - 1 + $urandom_range(0, 1);
                CMD_YEAR:       unit_yrs = 1;
                CMD_DECADE:     unit_yrs = 10;
                CMD_CENTURY:    unit_yrs = 100;
                CMD_MILLENNIUM: unit_yrs = 1000;
                default:        cnt = $urandom_range(0, 65535);
            endcase
            if (unit_yrs != 0)
            begin
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    cnt = ycl / unit_yrs + $urandom_range(0, 1);   // right at the underflow edge
                else if (pick == 2)
                    cnt = $urandom_range(0, 65535);
                else
                    cnt = $urandom_range(0, 20);
            end
            if (cnt > 65535)
                cnt = 65535;
            req.count = cnt[15:0];

            send_date(req, subtract_date(req));
        end

        s_axis_tvalid <= 1'b0;

        // ---- wait for every owed result, then a few more cycles for strays
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("calendar_date_subtractor_unit test passed");
        else
            $display("calendar_date_subtractor_unit test failed");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run (every item a full week walk)
    initial
    begin
        #100ms;
        $display("calendar_date_subtractor_unit test failed");
        $finish;
    end

endmodule
